// ----- src/smac_pkg.sv -----
// shared constants, types and helpers of the shadow memory access checker
package smac_pkg;

    localparam int ADDRESS_BITS     = 20;
    localparam int GRANULE_BITS     = 3;
    localparam int REDZONE_GRANULES = 1;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 20;
    localparam int LEN_W    = 21;
    localparam int SIZE_W   = 21;

    localparam int GRANULE   = 1 << GRANULE_BITS;
    localparam int CODE_W    = GRANULE_BITS + 1;
    localparam int DEPTH_AW  = ADDRESS_BITS - GRANULE_BITS;
    localparam int DEPTH     = 1 << DEPTH_AW;
    localparam int MEM_BYTES = 1 << ADDRESS_BITS;
    localparam int PTR_W     = LEN_W - GRANULE_BITS + 2;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CODE_FREE    = '0;
    localparam code_t CODE_FULL    = CODE_W'(GRANULE);
    localparam code_t CODE_REDZONE = CODE_W'(GRANULE + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // addressable bytes of a granule; redzone and unknown codes give none
    function automatic code_t avail_bytes(input code_t code);
        return (code != CODE_FREE && code <= CODE_FULL) ? code : CODE_FREE;
    endfunction

endpackage

// ----- src/smac_ram.sv -----
// generic simple dual port ram with registered read
module smac_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/shadow_memory_access_checker.sv -----
// top level of the shadow memory access checker
//
// Keeps one 4-bit shadow code per 8-byte granule of a 1 MiB address space in a
// single ram with one write and one read port. After reset the block sweeps
// the ram to zero, one granule per cycle, and holds s_ready low meanwhile.
// Each transaction then visits one granule per cycle. A check reads granules
// up to and including the first failing one, and reads none for zero length
// or a range past the end; a query counts granules in a walk; an allocate
// writes each granule of the region plus both redzones; a free counts the
// granules like a query and then clears them and their redzones. A finished
// result waits in the output register while the next transaction is accepted
// and processed; the block then holds in its last cycle until the waiting
// result is taken.
module shadow_memory_access_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [smac_pkg::ACTION_W-1:0]      s_action,
    input  logic [smac_pkg::ADDR_W-1:0]        s_address,
    input  logic [smac_pkg::LEN_W-1:0]         s_length,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_allowed,
    output logic [smac_pkg::ADDR_W-1:0]        m_fault_address,
    output logic [smac_pkg::SIZE_W-1:0]        m_size_found
);

    localparam int GB  = smac_pkg::GRANULE_BITS;
    localparam int AW  = smac_pkg::DEPTH_AW;
    localparam int PW  = smac_pkg::PTR_W;
    localparam int LW  = smac_pkg::LEN_W;
    localparam int SW  = smac_pkg::SIZE_W;
    localparam int ADW = smac_pkg::ADDR_W;

    function automatic logic [PW-1:0] first_granule(input logic [AW-1:0] base);
        if (base >= AW'(smac_pkg::REDZONE_GRANULES)) begin
            return PW'(base - AW'(smac_pkg::REDZONE_GRANULES));
        end
        return '0;
    endfunction

    smac_pkg::state_t state_reg, state_next;

    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [ADW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [GB-1:0]         off_reg, off_next;
    logic [LW-1:0]         rem_reg, rem_next;
    logic                  first_reg, first_next;
    logic                  head_reg, head_next;
    logic                  wr_free_reg, wr_free_next;
    logic [SW-1:0]         size_reg, size_next;
    logic                  res_allowed_reg, res_allowed_next;
    logic [ADW-1:0]        res_fault_reg, res_fault_next;
    logic [PW-1:0]         lim_full_reg, lim_full_next;
    logic [PW-1:0]         lim_span_reg, lim_span_next;
    logic [PW-1:0]         lim_end_reg, lim_end_next;
    smac_pkg::code_t       rem_code_reg, rem_code_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_allowed_reg, m_allowed_next;
    logic [ADW-1:0]        m_fault_reg, m_fault_next;
    logic [SW-1:0]         m_size_reg, m_size_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    smac_pkg::code_t       ram_wdata;
    logic [AW-1:0]         ram_raddr;
    smac_pkg::code_t       ram_rdata;

    smac_pkg::action_t     in_action;
    logic [AW-1:0]         in_gran;
    logic [GB-1:0]         in_off;
    logic [LW:0]           in_end;
    logic                  in_past;
    logic                  in_empty;
    logic [PW-1:0]         in_full_cnt;
    logic [PW-1:0]         in_lim_full;
    logic [PW-1:0]         in_lim_span;
    logic [PW-1:0]         in_lim_end;

    smac_pkg::code_t       rd_code;
    smac_pkg::code_t       chk_need;
    logic                  chk_fail;
    logic                  chk_last;
    logic                  walk_in_range;
    logic                  walk_head_bad;
    logic                  walk_stop;
    logic [SW-1:0]         walk_size_final;
    logic [SW:0]           walk_round;
    logic [PW-1:0]         walk_lim_end;
    logic                  wr_active;
    smac_pkg::code_t       wr_code;
    logic                  out_free;

    smac_ram #(
        .WIDTH (smac_pkg::CODE_W),
        .DEPTH (smac_pkg::DEPTH)
    ) u_shadow_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // input transaction decode
    assign in_action   = smac_pkg::action_t'(s_action);
    assign in_gran     = s_address[ADW-1:GB];
    assign in_off      = s_address[GB-1:0];
    assign in_end      = {1'b0, s_length} + (LW+1)'(s_address);
    assign in_past     = in_end > (LW+1)'(smac_pkg::MEM_BYTES);
    assign in_empty    = s_length == '0;
    assign in_full_cnt = PW'(s_length[LW-1:GB]);
    assign in_lim_full = PW'(in_gran) + in_full_cnt;
    assign in_lim_span = in_lim_full + PW'(s_length[GB-1:0] != '0);
    assign in_lim_end  = in_lim_span + PW'(smac_pkg::REDZONE_GRANULES);

    // range check step
    assign rd_code  = smac_pkg::avail_bytes(ram_rdata);
    assign chk_need = (rem_reg >= LW'(smac_pkg::GRANULE)) ? smac_pkg::CODE_FULL
                                                          : smac_pkg::code_t'(rem_reg[GB-1:0]);
    assign chk_fail = rd_code < chk_need;
    assign chk_last = rem_reg <= LW'(smac_pkg::GRANULE);

    // size walk step
    assign walk_in_range   = ptr_reg < PW'(smac_pkg::DEPTH);
    assign walk_head_bad   = head_reg && (rd_code != smac_pkg::CODE_FULL);
    assign walk_stop       = !walk_in_range || walk_head_bad || (rd_code == smac_pkg::CODE_FREE);
    assign walk_size_final = walk_head_bad ? '0 : size_reg;
    assign walk_round      = {1'b0, walk_size_final} + (SW+1)'(smac_pkg::GRANULE - 1);
    assign walk_lim_end    = PW'(base_reg) + PW'(walk_round[SW:GB])
                           + PW'(smac_pkg::REDZONE_GRANULES);

    // write sweep
    assign wr_active = (ptr_reg < lim_end_reg) && (ptr_reg < PW'(smac_pkg::DEPTH));

    always_comb begin
        if (wr_free_reg) begin
            wr_code = smac_pkg::CODE_FREE;
        end else if (ptr_reg < PW'(base_reg)) begin
            wr_code = smac_pkg::CODE_REDZONE;
        end else if (ptr_reg < lim_full_reg) begin
            wr_code = smac_pkg::CODE_FULL;
        end else if (ptr_reg < lim_span_reg) begin
            wr_code = rem_code_reg;
        end else begin
            wr_code = smac_pkg::CODE_REDZONE;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smac_pkg::ST_CLEAR: begin
                if (ptr_reg == PW'(smac_pkg::DEPTH - 1)) begin
                    state_next = smac_pkg::ST_IDLE;
                end
            end
            smac_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (in_action)
                        smac_pkg::ACT_CHECK: begin
                            state_next = (in_empty || in_past) ? smac_pkg::ST_FINISH
                                                               : smac_pkg::ST_CHECK;
                        end
                        smac_pkg::ACT_ALLOC: state_next = smac_pkg::ST_WRITE;
                        default:             state_next = smac_pkg::ST_WALK;
                    endcase
                end
            end
            smac_pkg::ST_CHECK: begin
                if (chk_fail || chk_last) begin
                    state_next = smac_pkg::ST_FINISH;
                end
            end
            smac_pkg::ST_WALK: begin
                if (walk_stop) begin
                    state_next = wr_free_reg ? smac_pkg::ST_WRITE : smac_pkg::ST_FINISH;
                end
            end
            smac_pkg::ST_WRITE: begin
                if (!wr_active) begin
                    state_next = smac_pkg::ST_FINISH;
                end
            end
            smac_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = smac_pkg::ST_IDLE;
                end
            end
            default: state_next = smac_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        ptr_next         = ptr_reg;
        addr_next        = addr_reg;
        base_next        = base_reg;
        off_next         = off_reg;
        rem_next         = rem_reg;
        first_next       = first_reg;
        head_next        = head_reg;
        wr_free_next     = wr_free_reg;
        size_next        = size_reg;
        res_allowed_next = res_allowed_reg;
        res_fault_next   = res_fault_reg;
        lim_full_next    = lim_full_reg;
        lim_span_next    = lim_span_reg;
        lim_end_next     = lim_end_reg;
        rem_code_next    = rem_code_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_allowed_next   = m_allowed_reg;
        m_fault_next     = m_fault_reg;
        m_size_next      = m_size_reg;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg[AW-1:0];
        ram_wdata        = wr_code;
        ram_raddr        = ptr_reg[AW-1:0] + 1'b1;

        case (state_reg)
            smac_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = smac_pkg::CODE_FREE;
                ptr_next  = ptr_reg + 1'b1;
            end
            smac_pkg::ST_IDLE: begin
                ram_raddr = in_gran;
                if (s_valid) begin
                    addr_next        = s_address;
                    base_next        = in_gran;
                    off_next         = in_off;
                    ptr_next         = PW'(in_gran);
                    rem_next         = s_length + LW'(in_off);
                    first_next       = 1'b1;
                    head_next        = in_off != '0;
                    wr_free_next     = in_action == smac_pkg::ACT_FREE;
                    size_next        = '0;
                    res_allowed_next = 1'b1;
                    res_fault_next   = '0;
                    case (in_action)
                        smac_pkg::ACT_CHECK: begin
                            if (!in_empty && in_past) begin
                                res_allowed_next = 1'b0;
                                res_fault_next   = s_address;
                            end
                        end
                        smac_pkg::ACT_ALLOC: begin
                            ptr_next      = first_granule(in_gran);
                            lim_full_next = in_lim_full;
                            lim_span_next = in_lim_span;
                            lim_end_next  = in_lim_end;
                            rem_code_next = smac_pkg::code_t'(s_length[GB-1:0]);
                        end
                        smac_pkg::ACT_FREE: begin
                            // free works on the granule-aligned address
                            head_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            smac_pkg::ST_CHECK: begin
                if (chk_fail) begin
                    res_allowed_next = 1'b0;
                    res_fault_next   = first_reg ? addr_reg
                                                 : {ptr_reg[AW-1:0], {GB{1'b0}}};
                end else if (!chk_last) begin
                    rem_next   = rem_reg - LW'(smac_pkg::GRANULE);
                    ptr_next   = ptr_reg + 1'b1;
                    first_next = 1'b0;
                end
            end
            smac_pkg::ST_WALK: begin
                if (walk_stop) begin
                    size_next    = walk_size_final;
                    ptr_next     = first_granule(base_reg);
                    lim_end_next = walk_lim_end;
                end else begin
                    if (head_reg) begin
                        size_next = SW'(smac_pkg::GRANULE) - SW'(off_reg);
                    end else begin
                        size_next = size_reg + SW'(rd_code);
                    end
                    head_next = 1'b0;
                    ptr_next  = ptr_reg + 1'b1;
                end
            end
            smac_pkg::ST_WRITE: begin
                if (wr_active) begin
                    ram_we   = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            smac_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_allowed_next = res_allowed_reg;
                    m_fault_next   = res_fault_reg;
                    m_size_next    = size_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smac_pkg::ST_CLEAR;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg        <= addr_next;
        base_reg        <= base_next;
        off_reg         <= off_next;
        rem_reg         <= rem_next;
        first_reg       <= first_next;
        head_reg        <= head_next;
        wr_free_reg     <= wr_free_next;
        size_reg        <= size_next;
        res_allowed_reg <= res_allowed_next;
        res_fault_reg   <= res_fault_next;
        lim_full_reg    <= lim_full_next;
        lim_span_reg    <= lim_span_next;
        lim_end_reg     <= lim_end_next;
        rem_code_reg    <= rem_code_next;
        m_allowed_reg   <= m_allowed_next;
        m_fault_reg     <= m_fault_next;
        m_size_reg      <= m_size_next;
    end

    assign s_ready         = state_reg == smac_pkg::ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_allowed       = m_allowed_reg;
    assign m_fault_address = m_fault_reg;
    assign m_size_found    = m_size_reg;

endmodule
